### rtl/pps_pkg.sv
// Package for the preemptive priority scheduler.
// Holds the table geometry, the job record type and the control state codes.
// No dependencies.
`timescale 1ns / 1ps

package pps_pkg;

  // Number of job slots and width of the tick counter.
  localparam int SLOTS     = 16;
  localparam int TIME_BITS = 16;

  // Fixed widths of the transaction fields.
  localparam int SLOT_FW = 4;
  localparam int TAG_W   = 16;
  localparam int TIME_FW = 16;
  localparam int PRIO_W  = 8;
  localparam int WORK_W  = 16;

  // Index width into the table and a counter wide enough to hold SLOTS itself.
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = SLOT_W + 1;

  // Width used for time arithmetic: wide enough for the clock plus one carry.
  localparam int CALC_W = ((TIME_BITS > TIME_FW) ? TIME_BITS : TIME_FW) + 1;

  // Width for comparing a 4-bit slot field against the table depth.
  localparam int SCMP_W = ((SLOT_FW > SLOT_W) ? SLOT_FW : SLOT_W) + 1;

  // One job slot as stored in the table memory.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [TIME_FW-1:0] arrival;
    logic [PRIO_W-1:0]  prio;
    logic [WORK_W-1:0]  burst;
    logic [WORK_W-1:0]  remaining;
  } job_rec_t;

  // Write request into the table.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] idx;
    job_rec_t          rec;
  } tbl_wr_t;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_WB   = 4'b1000
  } state_t;

  // Operation codes of an input transaction.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

endpackage

### rtl/preemptive_priority_scheduler.sv
// Top level of the preemptive priority scheduler.
// Sequences loads and tick scans over the job table and holds the result register.
// Depends on pps_pkg and pps_table.
`timescale 1ns / 1ps

// A load transaction writes one job slot and produces no result; a load to a slot
// beyond the table is dropped. A tick transaction reads the job table one slot per
// cycle through the table's single read port. After a tick is accepted, in_ready
// stays low while the block reads every slot, judges the last slot, then writes
// the served job's reduced work back and loads the result register. No new
// transaction is accepted until the tick has retired, and the write-back state
// holds for as long as the result register is full and out_ready is low. The
// served job is the valid slot with work left, an arrival time not later than the
// current tick and the smallest priority value; ties go to the lowest slot. Every
// tick yields exactly one result transaction, with ran low when nothing was ready.
// The tick counter advances after each tick and saturates at its maximum. The result
// register lets a new transaction be accepted while a result still waits for
// out_ready; a tick can only retire once that register is free. Slot valid flags
// are cleared by reset; there is no clearing pass over the table.
module preemptive_priority_scheduler (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [pps_pkg::SLOT_FW-1:0]   in_slot,
  input  logic [pps_pkg::TAG_W-1:0]     in_job_tag,
  input  logic [pps_pkg::TIME_FW-1:0]   in_arrival,
  input  logic [pps_pkg::PRIO_W-1:0]    in_prio,
  input  logic [pps_pkg::WORK_W-1:0]    in_burst,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ran,
  output logic [pps_pkg::SLOT_FW-1:0]   out_served_slot,
  output logic [pps_pkg::TAG_W-1:0]     out_served_tag,
  output logic                          out_finished,
  output logic [pps_pkg::TIME_FW-1:0]   out_wait_time,
  output logic [pps_pkg::TIME_FW-1:0]   out_turnaround,
  output logic [pps_pkg::TIME_FW-1:0]   out_time_now
);

  localparam int CW = pps_pkg::CALC_W;

  pps_pkg::state_t state_r, state_nxt;

  logic [pps_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [pps_pkg::SLOT_W-1:0]    eval_idx_r, eval_idx_nxt;
  logic [pps_pkg::TIME_BITS-1:0] time_r, time_nxt;

  // Best candidate found so far during a scan.
  logic                          found_r, found_nxt;
  logic [pps_pkg::SLOT_W-1:0]    best_idx_r, best_idx_nxt;
  pps_pkg::job_rec_t             best_rec_r, best_rec_nxt;

  // Result register.
  logic                          out_valid_r, out_valid_nxt;
  logic                          ran_r, ran_nxt;
  logic [pps_pkg::SLOT_FW-1:0]   served_slot_r, served_slot_nxt;
  logic [pps_pkg::TAG_W-1:0]     served_tag_r, served_tag_nxt;
  logic                          finished_r, finished_nxt;
  logic [pps_pkg::TIME_FW-1:0]   wait_time_r, wait_time_nxt;
  logic [pps_pkg::TIME_FW-1:0]   turnaround_r, turnaround_nxt;
  logic [pps_pkg::TIME_FW-1:0]   time_now_r, time_now_nxt;

  // Table interface.
  pps_pkg::tbl_wr_t              tbl_wr;
  logic                          tbl_rd_en;
  logic [pps_pkg::SLOT_W-1:0]    tbl_rd_idx;
  pps_pkg::job_rec_t             tbl_rd_rec;
  logic                          tbl_rd_valid;

  logic                          in_fire;
  logic                          eval_en;
  logic                          cand_ok;
  logic                          retire;
  logic                          slot_in_range;
  logic [CW-1:0]                 fin_time;
  logic [CW-1:0]                 tat_full;
  logic [CW-1:0]                 wait_full;
  logic [pps_pkg::WORK_W-1:0]    rem_dec;

  pps_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .rd_en    (tbl_rd_en),
    .rd_idx   (tbl_rd_idx),
    .rd_rec   (tbl_rd_rec),
    .rd_valid (tbl_rd_valid)
  );

  assign in_ready = (state_r == pps_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign slot_in_range =
    (pps_pkg::SCMP_W'(in_slot) < pps_pkg::SCMP_W'(pps_pkg::SLOTS));

  // Table data for the slot read in the previous cycle is judged while scanning
  // and in the final judging state.
  assign eval_en = (state_r == pps_pkg::ST_LAST) ||
                   ((state_r == pps_pkg::ST_SCAN) && (cnt_r != '0));

  // A slot is a candidate when it holds work, has arrived and beats the best so far.
  // A strict compare keeps the lowest slot on equal priority.
  assign cand_ok = tbl_rd_valid && (tbl_rd_rec.remaining != '0) &&
                   (CW'(tbl_rd_rec.arrival) <= CW'(time_r)) &&
                   (!found_r || (tbl_rd_rec.prio < best_rec_r.prio));

  // The tick retires once the result register can take its result.
  assign retire = (state_r == pps_pkg::ST_WB) && (!out_valid_r || out_ready);

  // Completion statistics for the served job; the finish time is the tick plus one.
  assign rem_dec   = best_rec_r.remaining - pps_pkg::WORK_W'(1);
  assign fin_time  = CW'(time_r) + CW'(1);
  assign tat_full  = fin_time - CW'(best_rec_r.arrival);
  assign wait_full = (tat_full > CW'(best_rec_r.burst)) ?
                     (tat_full - CW'(best_rec_r.burst)) : '0;

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    eval_idx_nxt    = eval_idx_r;
    time_nxt        = time_r;
    found_nxt       = found_r;
    best_idx_nxt    = best_idx_r;
    best_rec_nxt    = best_rec_r;
    out_valid_nxt   = out_valid_r;
    ran_nxt         = ran_r;
    served_slot_nxt = served_slot_r;
    served_tag_nxt  = served_tag_r;
    finished_nxt    = finished_r;
    wait_time_nxt   = wait_time_r;
    turnaround_nxt  = turnaround_r;
    time_now_nxt    = time_now_r;

    tbl_wr          = '0;
    tbl_rd_en       = 1'b0;
    tbl_rd_idx      = cnt_r[pps_pkg::SLOT_W-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (eval_en && cand_ok) begin
      found_nxt    = 1'b1;
      best_idx_nxt = eval_idx_r;
      best_rec_nxt = tbl_rd_rec;
    end

    unique case (state_r)
      pps_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_op == pps_pkg::OP_LOAD) begin
            // A load to a slot beyond the table is dropped.
            tbl_wr.en            = slot_in_range;
            tbl_wr.idx           = pps_pkg::SLOT_W'(in_slot);
            tbl_wr.rec.tag       = in_job_tag;
            tbl_wr.rec.arrival   = in_arrival;
            tbl_wr.rec.prio      = in_prio;
            tbl_wr.rec.burst     = in_burst;
            tbl_wr.rec.remaining = in_burst;
          end else begin
            cnt_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = pps_pkg::ST_SCAN;
          end
        end
      end

      pps_pkg::ST_SCAN: begin
        tbl_rd_en    = 1'b1;
        eval_idx_nxt = cnt_r[pps_pkg::SLOT_W-1:0];
        cnt_nxt      = cnt_r + pps_pkg::CNT_W'(1);
        if (cnt_r == pps_pkg::CNT_W'(pps_pkg::SLOTS - 1)) begin
          state_nxt = pps_pkg::ST_LAST;
        end
      end

      pps_pkg::ST_LAST: begin
        state_nxt = pps_pkg::ST_WB;
      end

      pps_pkg::ST_WB: begin
        if (retire) begin
          // Write the served job back with one tick less of work.
          tbl_wr.en            = found_r;
          tbl_wr.idx           = best_idx_r;
          tbl_wr.rec           = best_rec_r;
          tbl_wr.rec.remaining = rem_dec;

          out_valid_nxt   = 1'b1;
          ran_nxt         = found_r;
          served_slot_nxt = found_r ? pps_pkg::SLOT_FW'(best_idx_r) : '0;
          served_tag_nxt  = found_r ? best_rec_r.tag : '0;
          finished_nxt    = 1'b0;
          wait_time_nxt   = '0;
          turnaround_nxt  = '0;
          if (found_r && (rem_dec == '0)) begin
            finished_nxt   = 1'b1;
            wait_time_nxt  = (wait_full > CW'({pps_pkg::TIME_FW{1'b1}})) ?
                             {pps_pkg::TIME_FW{1'b1}} :
                             pps_pkg::TIME_FW'(wait_full);
            turnaround_nxt = (tat_full > CW'({pps_pkg::TIME_FW{1'b1}})) ?
                             {pps_pkg::TIME_FW{1'b1}} :
                             pps_pkg::TIME_FW'(tat_full);
          end
          time_now_nxt = pps_pkg::TIME_FW'(time_r);

          // The tick counter stops at its maximum.
          if (time_r != {pps_pkg::TIME_BITS{1'b1}}) begin
            time_nxt = time_r + pps_pkg::TIME_BITS'(1);
          end
          state_nxt = pps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = pps_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pps_pkg::ST_IDLE;
      cnt_r       <= '0;
      time_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      time_r      <= time_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    eval_idx_r    <= eval_idx_nxt;
    best_idx_r    <= best_idx_nxt;
    best_rec_r    <= best_rec_nxt;
    ran_r         <= ran_nxt;
    served_slot_r <= served_slot_nxt;
    served_tag_r  <= served_tag_nxt;
    finished_r    <= finished_nxt;
    wait_time_r   <= wait_time_nxt;
    turnaround_r  <= turnaround_nxt;
    time_now_r    <= time_now_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ran         = ran_r;
  assign out_served_slot = served_slot_r;
  assign out_served_tag  = served_tag_r;
  assign out_finished    = finished_r;
  assign out_wait_time   = wait_time_r;
  assign out_turnaround  = turnaround_r;
  assign out_time_now    = time_now_r;

endmodule

### rtl/pps_table.sv
// Job table of the preemptive priority scheduler.
// One synchronous memory of job records with a registered read, plus per-slot valid flags.
// Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pps_pkg::tbl_wr_t                wr,
  input  logic                            rd_en,
  input  logic [pps_pkg::SLOT_W-1:0]      rd_idx,
  output pps_pkg::job_rec_t               rd_rec,
  output logic                            rd_valid
);

  pps_pkg::job_rec_t mem [pps_pkg::SLOTS];

  logic [pps_pkg::SLOTS-1:0] valid_r;
  pps_pkg::job_rec_t         rd_rec_r;
  logic                      rd_valid_r;

  // Record storage: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.rec;
    end
    if (rd_en) begin
      rd_rec_r <= mem[rd_idx];
    end
  end

  // Valid flags are cleared at reset and set by any write to the slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.en) begin
        valid_r[wr.idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_idx];
      end
    end
  end

  assign rd_rec   = rd_rec_r;
  assign rd_valid = rd_valid_r;

endmodule

### tb/testbench.sv
// Self-checking testbench for the preemptive priority scheduler.
// Drives load and tick transactions, predicts every tick result and scores the outputs.
// Depends on pps_pkg and the preemptive_priority_scheduler RTL.
`timescale 1ns / 1ps

// The testbench has two stimulus phases. A short directed table comes first. It
// starts from reset and walks through an idle tick, ties on priority, a job with no
// work, a late arrival, preemption by a better priority, the reload of a busy slot and
// the extremes of every field. A random phase of about 700 transactions follows.
// During it the receiver holds off once for a long stretch, and the sender pauses
// once until the block has drained.
//
// Every accepted transaction goes through the scheduler predictor below. A tick
// always yields exactly one result, and its prediction is queued in order. The result
// monitor compares each accepted result, field by field, with the oldest queued
// prediction.
module testbench;

  // One result transaction as the block presents it.
  typedef struct packed {
    logic                        ran;
    logic [pps_pkg::SLOT_FW-1:0] slot;
    logic [pps_pkg::TAG_W-1:0]   tag;
    logic                        fin;
    logic [pps_pkg::TIME_FW-1:0] wait_t;
    logic [pps_pkg::TIME_FW-1:0] tat;
    logic [pps_pkg::TIME_FW-1:0] now;
  } sched_res_t;

  // One row of the directed table. When typed is set, the expected result is written
  // out in the row and replaces the predicted one.
  typedef struct packed {
    logic                        op;
    logic [pps_pkg::SLOT_FW-1:0] slot;
    logic [pps_pkg::TAG_W-1:0]   tag;
    logic [pps_pkg::TIME_FW-1:0] arrival;
    logic [pps_pkg::PRIO_W-1:0]  prio;
    logic [pps_pkg::WORK_W-1:0]  burst;
    logic                        typed;
    sched_res_t                  res;
  } dir_row_t;

  localparam sched_res_t NO_RES = '0;
  localparam int DIR_ROWS    = 20;
  localparam int RAND_ITEMS  = 700;
  localparam int IDLE_PCT    = 34;
  localparam int HOLD_CYC    = 400;
  // A tick keeps the block busy while it scans every slot. Leave some margin on top.
  localparam int SETTLE_CYC  = pps_pkg::SLOTS + 8;
  localparam longint LIMIT_NS = 3_000_000;
  localparam logic [pps_pkg::TIME_BITS-1:0] TICK_MAX = {pps_pkg::TIME_BITS{1'b1}};

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic                        in_op;
  logic [pps_pkg::SLOT_FW-1:0] in_slot;
  logic [pps_pkg::TAG_W-1:0]   in_job_tag;
  logic [pps_pkg::TIME_FW-1:0] in_arrival;
  logic [pps_pkg::PRIO_W-1:0]  in_prio;
  logic [pps_pkg::WORK_W-1:0]  in_burst;
  logic                        out_valid;
  logic                        out_ready;
  logic                        out_ran;
  logic [pps_pkg::SLOT_FW-1:0] out_served_slot;
  logic [pps_pkg::TAG_W-1:0]   out_served_tag;
  logic                        out_finished;
  logic [pps_pkg::TIME_FW-1:0] out_wait_time;
  logic [pps_pkg::TIME_FW-1:0] out_turnaround;
  logic [pps_pkg::TIME_FW-1:0] out_time_now;

  // Job table as the predictor sees it, and its copy of the tick counter.
  logic                          job_live  [pps_pkg::SLOTS];
  logic [pps_pkg::TAG_W-1:0]     job_tag   [pps_pkg::SLOTS];
  logic [pps_pkg::TIME_FW-1:0]   job_arr   [pps_pkg::SLOTS];
  logic [pps_pkg::PRIO_W-1:0]    job_prio  [pps_pkg::SLOTS];
  logic [pps_pkg::WORK_W-1:0]    job_left  [pps_pkg::SLOTS];
  logic [pps_pkg::WORK_W-1:0]    job_burst [pps_pkg::SLOTS];
  logic [pps_pkg::TIME_BITS-1:0] now_tick;

  sched_res_t pending_res [$];
  int         err_cnt = 0;

  // The idle_on flag enables random idling on both sides. The hold_req flag asks the
  // result monitor for one long hold-off.
  bit idle_on;
  bit hold_req;

  // In the directed table, each tick is followed by its expected result. The slot
  // with arrival 16'hFFFF stays waiting, since the tick counter never gets that far.
  dir_row_t dir_rows [DIR_ROWS] = '{
    // This tick runs right after reset with an empty table, so it is idle.
    '{pps_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1,
      '{1'b0, 4'd0, 16'h0000, 1'b0, 16'd0, 16'd0, 16'd0}},
    '{pps_pkg::OP_LOAD, 4'd15, 16'hFFFF, 16'h0000, 8'hFF, 16'd2, 1'b0, NO_RES},
    '{pps_pkg::OP_LOAD, 4'd0, 16'h0000, 16'h0000, 8'hFF, 16'd1, 1'b0, NO_RES},
    // Slots 0 and 15 tie on priority, so the lower slot wins and finishes.
    '{pps_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1,
      '{1'b1, 4'd0, 16'h0000, 1'b1, 16'd1, 16'd2, 16'd1}},
    // This job has no work, so it is never served in spite of its best priority.
    '{pps_pkg::OP_LOAD, 4'd7, 16'h1234, 16'h0000, 8'h00, 16'd0, 1'b0, NO_RES},
    '{pps_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1,
      '{1'b1, 4'd15, 16'hFFFF, 1'b0, 16'd0, 16'd0, 16'd2}},
    '{pps_pkg::OP_LOAD, 4'd3, 16'h00A5, 16'd5, 8'h00, 16'd1, 1'b0, NO_RES},
    '{pps_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1,
      '{1'b1, 4'd15, 16'hFFFF, 1'b1, 16'd2, 16'd4, 16'd3}},
    // Slot 3 has not arrived yet, so this tick is idle.
    '{pps_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1,
      '{1'b0, 4'd0, 16'h0000, 1'b0, 16'd0, 16'd0, 16'd4}},
    '{pps_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1,
      '{1'b1, 4'd3, 16'h00A5, 1'b1, 16'd0, 16'd1, 16'd5}},
    '{pps_pkg::OP_LOAD, 4'd8, 16'h5A5A, 16'h0000, 8'h80, 16'hFFFF, 1'b0, NO_RES},
    '{pps_pkg::OP_LOAD, 4'd9, 16'hA5A5, 16'hFFFF, 8'h00, 16'd3, 1'b0, NO_RES},
    '{pps_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1,
      '{1'b1, 4'd8, 16'h5A5A, 1'b0, 16'd0, 16'd0, 16'd6}},
    // A job with a better priority preempts slot 8.
    '{pps_pkg::OP_LOAD, 4'd4, 16'h4444, 16'h0000, 8'h10, 16'd2, 1'b0, NO_RES},
    '{pps_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1,
      '{1'b1, 4'd4, 16'h4444, 1'b0, 16'd0, 16'd0, 16'd7}},
    // Reloading slot 4 replaces its remaining work, so it finishes on the next tick.
    '{pps_pkg::OP_LOAD, 4'd4, 16'h4445, 16'd3, 8'h10, 16'd1, 1'b0, NO_RES},
    '{pps_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1,
      '{1'b1, 4'd4, 16'h4445, 1'b1, 16'd5, 16'd6, 16'd8}},
    '{pps_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1,
      '{1'b1, 4'd8, 16'h5A5A, 1'b0, 16'd0, 16'd0, 16'd9}},
    '{pps_pkg::OP_LOAD, 4'd8, 16'h5A5B, 16'd2, 8'h7F, 16'd1, 1'b0, NO_RES},
    '{pps_pkg::OP_TICK, 4'd0, 16'h0000, 16'h0000, 8'h00, 16'h0000, 1'b1,
      '{1'b1, 4'd8, 16'h5A5B, 1'b1, 16'd8, 16'd9, 16'd10}}
  };

  preemptive_priority_scheduler u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_slot         (in_slot),
    .in_job_tag      (in_job_tag),
    .in_arrival      (in_arrival),
    .in_prio         (in_prio),
    .in_burst        (in_burst),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ran         (out_ran),
    .out_served_slot (out_served_slot),
    .out_served_tag  (out_served_tag),
    .out_finished    (out_finished),
    .out_wait_time   (out_wait_time),
    .out_turnaround  (out_turnaround),
    .out_time_now    (out_time_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Counts a mismatch and prints one line for it.
  task automatic log_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // This is the scheduler predictor. A load fills a slot. A tick serves the ready
  // job with the smallest priority value and the lowest slot, then advances the
  // saturating tick counter.
  task automatic sched_predict(input logic op, input logic [pps_pkg::SLOT_FW-1:0] slot,
                               input logic [pps_pkg::TAG_W-1:0] tag,
                               input logic [pps_pkg::TIME_FW-1:0] arrival,
                               input logic [pps_pkg::PRIO_W-1:0] prio,
                               input logic [pps_pkg::WORK_W-1:0] burst,
                               output bit has_res, output sched_res_t res);
    bit                         found;
    int                         pick;
    logic [pps_pkg::CALC_W-1:0] fin;
    logic [pps_pkg::CALC_W-1:0] tat;
    logic [pps_pkg::CALC_W-1:0] wt;
    res     = '0;
    has_res = 1'b0;
    found   = 1'b0;
    pick    = 0;
    if (op == pps_pkg::OP_LOAD) begin
      if (slot < pps_pkg::SLOTS) begin
        job_live[slot]  = 1'b1;
        job_tag[slot]   = tag;
        job_arr[slot]   = arrival;
        job_prio[slot]  = prio;
        job_burst[slot] = burst;
        job_left[slot]  = burst;
      end
    end else begin
      for (int i = 0; i < pps_pkg::SLOTS; i++) begin
        if (job_live[i] && job_left[i] != '0 && job_arr[i] <= now_tick &&
            (!found || job_prio[i] < job_prio[pick])) begin
          found = 1'b1;
          pick  = i;
        end
      end
      has_res = 1'b1;
      if (found) begin
        res.ran = 1'b1;
        res.slot = pps_pkg::SLOT_FW'(pick);
        res.tag = job_tag[pick];
        job_left[pick] = job_left[pick] - 1'b1;
        if (job_left[pick] == '0) begin
          // The finish time is one past the tick just processed. Once the counter
          // has saturated, the turnaround can fall below the burst. The wait is then
          // clamped to zero.
          fin = pps_pkg::CALC_W'(now_tick) + 1'b1;
          tat = fin - pps_pkg::CALC_W'(job_arr[pick]);
          wt  = (tat > pps_pkg::CALC_W'(job_burst[pick])) ?
                tat - pps_pkg::CALC_W'(job_burst[pick]) : '0;
          res.fin    = 1'b1;
          res.wait_t = (wt > pps_pkg::CALC_W'(16'hFFFF)) ?
                       16'hFFFF : wt[pps_pkg::TIME_FW-1:0];
          res.tat    = (tat > pps_pkg::CALC_W'(16'hFFFF)) ?
                       16'hFFFF : tat[pps_pkg::TIME_FW-1:0];
        end
      end
      res.now = now_tick[pps_pkg::TIME_FW-1:0];
      if (now_tick != TICK_MAX) now_tick = now_tick + 1'b1;
    end
  endtask

  // Offers one transaction. It is entered right after a rising edge. With idling on,
  // valid may drop for a random gap first, and the payload carries junk during the gap.
  // Otherwise valid stays high straight into the next transaction. The prediction is
  // taken at the accepting edge.
  task automatic offer_job(input logic op, input logic [pps_pkg::SLOT_FW-1:0] slot,
                           input logic [pps_pkg::TAG_W-1:0] tag,
                           input logic [pps_pkg::TIME_FW-1:0] arrival,
                           input logic [pps_pkg::PRIO_W-1:0] prio,
                           input logic [pps_pkg::WORK_W-1:0] burst,
                           input bit typed, input sched_res_t typed_res);
    bit         has_res;
    sched_res_t res;
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid   <= 1'b0;
      in_op      <= 1'($urandom);
      in_slot    <= pps_pkg::SLOT_FW'($urandom);
      in_job_tag <= pps_pkg::TAG_W'($urandom);
      in_arrival <= pps_pkg::TIME_FW'($urandom);
      in_prio    <= pps_pkg::PRIO_W'($urandom);
      in_burst   <= pps_pkg::WORK_W'($urandom);
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_slot    <= slot;
    in_job_tag <= tag;
    in_arrival <= arrival;
    in_prio    <= prio;
    in_burst   <= burst;
    do @(posedge clk); while (in_ready !== 1'b1);
    sched_predict(op, slot, tag, arrival, prio, burst, has_res, res);
    if (has_res) pending_res.push_back(typed ? typed_res : res);
  endtask

  // Builds one random transaction. Loads get an arrival mostly near the current tick,
  // so that jobs really compete. They get a small burst, so that many of them finish,
  // and a narrow priority range half of the time, so that ties come up often. Full
  // range values are mixed in for every field.
  task automatic offer_random_job();
    logic                        op;
    logic [pps_pkg::TIME_FW-1:0] arrival;
    logic [pps_pkg::WORK_W-1:0]  burst;
    logic [pps_pkg::PRIO_W-1:0]  prio;
    int                          back;
    int                          pick;
    op   = ($urandom_range(0, 99) < 40) ? pps_pkg::OP_LOAD : pps_pkg::OP_TICK;
    pick = $urandom_range(0, 99);
    back = $urandom_range(0, 20);
    if (pick < 60)
      arrival = (now_tick > back) ? pps_pkg::TIME_FW'(now_tick - back) : '0;
    else if (pick < 85)
      arrival = pps_pkg::TIME_FW'(now_tick + $urandom_range(1, 30));
    else
      arrival = pps_pkg::TIME_FW'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 70)      burst = pps_pkg::WORK_W'($urandom_range(1, 6));
    else if (pick < 90) burst = pps_pkg::WORK_W'($urandom_range(7, 40));
    else                burst = pps_pkg::WORK_W'($urandom_range(1, 65535));
    prio = ($urandom_range(0, 1) == 0) ? pps_pkg::PRIO_W'($urandom_range(0, 3)) :
                                         pps_pkg::PRIO_W'($urandom);
    offer_job(op, pps_pkg::SLOT_FW'($urandom), pps_pkg::TAG_W'($urandom), arrival, prio,
              burst, 1'b0, NO_RES);
  endtask

  // Drops valid and waits until every predicted result has arrived. It then waits
  // out one more tick's worth of cycles, so that the block is fully idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Compares one accepted result with the oldest prediction.
  task automatic check_result();
    sched_res_t want;
    if (pending_res.size() == 0) begin
      log_mismatch($sformatf("result with no tick pending (time_now %0d)", out_time_now));
      return;
    end
    want = pending_res.pop_front();
    if (out_ran !== want.ran)
      log_mismatch($sformatf("t=%0d ran %0d, want %0d", want.now, out_ran, want.ran));
    if (out_served_slot !== want.slot)
      log_mismatch($sformatf("t=%0d served_slot %0d, want %0d", want.now,
                             out_served_slot, want.slot));
    if (out_served_tag !== want.tag)
      log_mismatch($sformatf("t=%0d served_tag %h, want %h", want.now,
                             out_served_tag, want.tag));
    if (out_finished !== want.fin)
      log_mismatch($sformatf("t=%0d finished %0d, want %0d", want.now,
                             out_finished, want.fin));
    if (out_wait_time !== want.wait_t)
      log_mismatch($sformatf("t=%0d wait_time %0d, want %0d", want.now,
                             out_wait_time, want.wait_t));
    if (out_turnaround !== want.tat)
      log_mismatch($sformatf("t=%0d turnaround %0d, want %0d", want.now,
                             out_turnaround, want.tat));
    if (out_time_now !== want.now)
      log_mismatch($sformatf("time_now %0d, want %0d", out_time_now, want.now));
  endtask

  // The result monitor samples at each rising edge, and then decides the next
  // out_ready. A hold-off request keeps out_ready low until its hold count has run out.
  // That count runs down here, while the sender keeps offering transactions.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) check_result();
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (idle_on) begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    for (int i = 0; i < pps_pkg::SLOTS; i++) begin
      job_live[i]  = 1'b0;
      job_tag[i]   = '0;
      job_arr[i]   = '0;
      job_prio[i]  = '0;
      job_left[i]  = '0;
      job_burst[i] = '0;
    end
    now_tick   = '0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = pps_pkg::OP_LOAD;
    in_slot    = '0;
    in_job_tag = '0;
    in_arrival = '0;
    in_prio    = '0;
    in_burst   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      offer_job(dir_rows[i].op, dir_rows[i].slot, dir_rows[i].tag, dir_rows[i].arrival,
                dir_rows[i].prio, dir_rows[i].burst, dir_rows[i].typed, dir_rows[i].res);
    settle();

    // During the random phase, idling is switched off for one long stretch. The long
    // receiver hold-off fills the block and stalls its input. The sender also pauses
    // once until every result is in.
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k == 150) idle_on = 1'b0;
      if (k == 300) idle_on = 1'b1;
      if (k == 400) hold_req = 1'b1;
      if (k == 550) settle();
      offer_random_job();
    end
    settle();

    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
rtl/pps_pkg.sv
rtl/pps_table.sv
rtl/preemptive_priority_scheduler.sv
tb/testbench.sv
